[rtl/lft_pkg.sv]
// shared types, constants and the cordic arctangent table for the frame transform
// no dependencies
package lft_pkg;

    localparam int COORD_WIDTH_DEF = 48;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int ANGLE_WIDTH_DEF = 32;

    localparam int CORDIC_ITERS = 30;
    localparam int CS_FRAC      = 30;
    localparam int CS_W         = 33;
    localparam int Z_W          = 32;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // stage counts used for alignment
    localparam int CORDIC_LAT = CORDIC_ITERS + 1;
    localparam int ROT_LAT    = 3;

    typedef enum logic [1:0] {
        REQ_FWD  = 2'd0,
        REQ_REV  = 2'd1,
        REQ_BASE = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [Z_W-1:0] atan_turns(input int idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            0:  r = 32'sh20000000;
            1:  r = 32'sh12E4051E;
            2:  r = 32'sh09FB385B;
            3:  r = 32'sh051111D4;
            4:  r = 32'sh028B0D43;
            5:  r = 32'sh0145D7E1;
            6:  r = 32'sh00A2F61E;
            7:  r = 32'sh00517C55;
            8:  r = 32'sh0028BE53;
            9:  r = 32'sh00145F2F;
            10: r = 32'sh000A2F98;
            11: r = 32'sh000517CC;
            12: r = 32'sh00028BE6;
            13: r = 32'sh000145F3;
            14: r = 32'sh0000A2FA;
            15: r = 32'sh0000517D;
            16: r = 32'sh000028BE;
            17: r = 32'sh0000145F;
            18: r = 32'sh00000A30;
            19: r = 32'sh00000518;
            20: r = 32'sh0000028C;
            21: r = 32'sh00000146;
            22: r = 32'sh000000A3;
            23: r = 32'sh00000051;
            24: r = 32'sh00000029;
            25: r = 32'sh00000014;
            26: r = 32'sh0000000A;
            27: r = 32'sh00000005;
            28: r = 32'sh00000003;
            29: r = 32'sh00000001;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/lft_cordic.sv]
// pipelined cordic: 32-bit binary angle to cosine and sine in signed q2.30 (33 bits, 30 fraction bits)
// depends on lft_pkg
module lft_cordic
    import lft_pkg::*;
(
    input  logic                   aclk,
    input  logic                   en,
    input  logic [31:0]            angle,
    output logic signed [CS_W-1:0] cos_out,
    output logic signed [CS_W-1:0] sin_out
);

    logic signed [CS_W-1:0] x_reg [CORDIC_ITERS];
    logic signed [CS_W-1:0] y_reg [CORDIC_ITERS];
    logic signed [Z_W-1:0]  z_reg [CORDIC_ITERS];
    logic [1:0]             q_reg [CORDIC_ITERS];
    logic signed [CS_W-1:0] cos_reg;
    logic signed [CS_W-1:0] sin_reg;

    genvar i;
    generate
        for (i = 0; i < CORDIC_ITERS; i++) begin : g_iter
            logic signed [CS_W-1:0] x_in;
            logic signed [CS_W-1:0] y_in;
            logic signed [Z_W-1:0]  z_in;
            logic [1:0]             q_in;
            logic signed [CS_W-1:0] x_next;
            logic signed [CS_W-1:0] y_next;
            logic signed [Z_W-1:0]  z_next;

            if (i == 0) begin : g_first
                assign x_in = CORDIC_GAIN;
                assign y_in = '0;
                assign z_in = $signed({2'b00, angle[29:0]});
                assign q_in = angle[31:30];
            end else begin : g_rest
                assign x_in = x_reg[i-1];
                assign y_in = y_reg[i-1];
                assign z_in = z_reg[i-1];
                assign q_in = q_reg[i-1];
            end

            always_comb begin
                if (!z_in[Z_W-1]) begin
                    x_next = x_in - (y_in >>> i);
                    y_next = y_in + (x_in >>> i);
                    z_next = z_in - atan_turns(i);
                end else begin
                    x_next = x_in + (y_in >>> i);
                    y_next = y_in - (x_in >>> i);
                    z_next = z_in + atan_turns(i);
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[i] <= x_next;
                    y_reg[i] <= y_next;
                    z_reg[i] <= z_next;
                    q_reg[i] <= q_in;
                end
            end
        end
    endgenerate

    // quadrant fold
    always_ff @(posedge aclk) begin
        if (en) begin
            case (q_reg[CORDIC_ITERS-1])
                2'd0: begin
                    cos_reg <= x_reg[CORDIC_ITERS-1];
                    sin_reg <= y_reg[CORDIC_ITERS-1];
                end
                2'd1: begin
                    cos_reg <= -y_reg[CORDIC_ITERS-1];
                    sin_reg <= x_reg[CORDIC_ITERS-1];
                end
                2'd2: begin
                    cos_reg <= -x_reg[CORDIC_ITERS-1];
                    sin_reg <= -y_reg[CORDIC_ITERS-1];
                end
                default: begin
                    cos_reg <= y_reg[CORDIC_ITERS-1];
                    sin_reg <= -x_reg[CORDIC_ITERS-1];
                end
            endcase
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

[rtl/lft_rotate.sv]
// three-stage rotation by [c s; -s c] with split multiplies and round half up
// depends on lft_pkg
module lft_rotate
    import lft_pkg::*;
#(
    parameter int UW = COORD_WIDTH_DEF + 1,
    parameter int RW = COORD_WIDTH_DEF + 3
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [UW-1:0]   u,
    input  logic signed [UW-1:0]   v,
    input  logic signed [CS_W-1:0] c,
    input  logic signed [CS_W-1:0] s,
    output logic signed [RW-1:0]   ru,
    output logic signed [RW-1:0]   rv
);

    localparam int LO_W  = UW / 2;
    localparam int HI_W  = UW - LO_W;
    localparam int PL_W  = LO_W + 1 + CS_W;
    localparam int PH_W  = HI_W + CS_W;
    localparam int PW    = UW + CS_W + 3;

    // stage 1: partial products
    logic signed [PL_W-1:0] uc_l_reg, us_l_reg, vc_l_reg, vs_l_reg;
    logic signed [PH_W-1:0] uc_h_reg, us_h_reg, vc_h_reg, vs_h_reg;
    // stage 2: full products
    logic signed [PW-1:0] uc_reg, us_reg, vc_reg, vs_reg;
    // stage 3: rounded sums
    logic signed [RW-1:0] ru_reg, rv_reg;

    logic signed [LO_W:0]   u_lo, v_lo;
    logic signed [HI_W-1:0] u_hi, v_hi;
    logic signed [PW-1:0]   sum_u, sum_v;
    logic signed [PW-1:0]   half;

    assign u_lo = $signed({1'b0, u[LO_W-1:0]});
    assign v_lo = $signed({1'b0, v[LO_W-1:0]});
    assign u_hi = u[UW-1:LO_W];
    assign v_hi = v[UW-1:LO_W];
    assign half = PW'(1) <<< (CS_FRAC - 1);

    function automatic logic signed [PW-1:0] join_pp(input logic signed [PH_W-1:0] hi,
                                                     input logic signed [PL_W-1:0] lo);
        logic signed [PW-1:0] r;
        r = ((PW'(hi)) <<< LO_W) + PW'(lo);
        return r;
    endfunction

    assign sum_u = uc_reg + vs_reg + half;
    assign sum_v = vc_reg - us_reg + half;

    always_ff @(posedge aclk) begin
        if (en) begin
            uc_l_reg <= u_lo * c;
            us_l_reg <= u_lo * s;
            vc_l_reg <= v_lo * c;
            vs_l_reg <= v_lo * s;
            uc_h_reg <= u_hi * c;
            us_h_reg <= u_hi * s;
            vc_h_reg <= v_hi * c;
            vs_h_reg <= v_hi * s;

            uc_reg <= join_pp(uc_h_reg, uc_l_reg);
            us_reg <= join_pp(us_h_reg, us_l_reg);
            vc_reg <= join_pp(vc_h_reg, vc_l_reg);
            vs_reg <= join_pp(vs_h_reg, vs_l_reg);

            ru_reg <= RW'(sum_u >>> CS_FRAC);
            rv_reg <= RW'(sum_v >>> CS_FRAC);
        end
    end

    assign ru = ru_reg;
    assign rv = rv_reg;

endmodule

[rtl/local_frame_transform.sv]
// top level of the local/global frame transform: input prep, delay lines,
// cordic, rotation and the saturating output stage; depends on lft_pkg,
// lft_cordic and lft_rotate
//
// usage
//   s_ channel: one request per beat. s_tdata from bit 0 up holds req_type,
//   base_x, base_y, point_x, point_y, angle; s_tuser carries turn_left.
//   m_ channel: one result per beat. m_tdata holds result_x then result_y;
//   m_tuser carries the saturated flag.
// pipeline: 36 register stages (1 prep stage, 30 cordic iterations plus a
//   quadrant fold, 3 rotation stages, 1 output stage with the final add and
//   clip); the prep stage loads at the accepting edge, and m_tvalid rises
//   once the beat has passed through all of them into the output stage.
// throughput: one beat per cycle; every stage is a register and the whole
//   pipe moves whenever the output register is empty or being taken.
// stall: when m_tvalid is high and m_tready low the pipe freezes and
//   s_tready drops in the same cycle; nothing is lost or repeated.
// reset: aresetn low clears all valid bits; no result is pending after it.
//   the data registers are not reset.
module local_frame_transform
    import lft_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    localparam int IN_BITS  = 2 + 4 * COORD_WIDTH + ANGLE_WIDTH + FRAC_BITS * 0,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // req_type, base_x, base_y, point_x, point_y, angle
    input  logic [IN_W-1:0]  s_tdata,
    // turn_left
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // result_x, result_y
    output logic [OUT_W-1:0] m_tdata,
    // saturated
    output logic             m_tuser
);

    localparam int CW    = COORD_WIDTH;
    localparam int UW    = CW + 1;
    localparam int RW    = CW + 3;
    localparam int FW    = CW + 4;
    localparam int DLY_UV = CORDIC_LAT;
    localparam int DLY_B  = CORDIC_LAT + ROT_LAT;
    localparam int NSTG   = 1 + CORDIC_LAT + ROT_LAT + 1;

    localparam logic signed [FW-1:0] MAXV = FW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [FW-1:0] MINV = -(FW'(1) <<< (CW - 1));

    // field taps from the input beat
    logic [1:0]             in_req;
    logic signed [CW-1:0]   in_bx, in_by, in_px, in_py;
    logic [ANGLE_WIDTH-1:0] in_ang;
    logic                   adv;

    assign in_req = s_tdata[1:0];
    assign in_bx  = s_tdata[2 +: CW];
    assign in_by  = s_tdata[2 + CW +: CW];
    assign in_px  = s_tdata[2 + 2 * CW +: CW];
    assign in_py  = s_tdata[2 + 3 * CW +: CW];
    assign in_ang = s_tdata[2 + 4 * CW +: ANGLE_WIDTH];

    // whole pipe moves when the output slot frees up
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // valid bit per stage; the last one is m_tvalid
    logic [NSTG-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // prep stage: rotation operands per mode, left-aligned angle
    logic signed [UW-1:0] u_next, v_next;
    logic signed [UW-1:0] u_reg, v_reg;
    logic signed [CW-1:0] bx_reg, by_reg;
    req_t                 req_reg;
    logic                 left_reg;
    logic [31:0]          ang_reg;

    always_comb begin
        if (req_t'(in_req) == REQ_REV) begin
            u_next = UW'(in_px) - UW'(in_bx);
            v_next = UW'(in_py) - UW'(in_by);
        end else begin
            u_next = UW'(in_px);
            v_next = s_tuser ? UW'(in_py) : -UW'(in_py);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            bx_reg   <= in_bx;
            by_reg   <= in_by;
            req_reg  <= req_t'(in_req);
            left_reg <= s_tuser;
            ang_reg  <= 32'(in_ang) << (32 - ANGLE_WIDTH);
        end
    end

    // sine and cosine
    logic signed [CS_W-1:0] cos_w, sin_w;

    lft_cordic u_cordic (
        .aclk    (aclk),
        .en      (adv),
        .angle   (ang_reg),
        .cos_out (cos_w),
        .sin_out (sin_w)
    );

    // operands wait for the cordic; base, mode and turn bit also wait for the rotation
    logic signed [UW-1:0] u_dly_reg [DLY_UV];
    logic signed [UW-1:0] v_dly_reg [DLY_UV];
    logic signed [CW-1:0] bx_dly_reg [DLY_B];
    logic signed [CW-1:0] by_dly_reg [DLY_B];
    req_t                 req_dly_reg [DLY_B];
    logic                 left_dly_reg [DLY_B];

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_dly_reg[0]    <= u_reg;
            v_dly_reg[0]    <= v_reg;
            bx_dly_reg[0]   <= bx_reg;
            by_dly_reg[0]   <= by_reg;
            req_dly_reg[0]  <= req_reg;
            left_dly_reg[0] <= left_reg;
            for (int k = 1; k < DLY_UV; k++) begin
                u_dly_reg[k] <= u_dly_reg[k-1];
                v_dly_reg[k] <= v_dly_reg[k-1];
            end
            for (int k = 1; k < DLY_B; k++) begin
                bx_dly_reg[k]   <= bx_dly_reg[k-1];
                by_dly_reg[k]   <= by_dly_reg[k-1];
                req_dly_reg[k]  <= req_dly_reg[k-1];
                left_dly_reg[k] <= left_dly_reg[k-1];
            end
        end
    end

    // rotation
    logic signed [RW-1:0] ru_w, rv_w;

    lft_rotate #(
        .UW (UW),
        .RW (RW)
    ) u_rotate (
        .aclk (aclk),
        .en   (adv),
        .u    (u_dly_reg[DLY_UV-1]),
        .v    (v_dly_reg[DLY_UV-1]),
        .c    (cos_w),
        .s    (sin_w),
        .ru   (ru_w),
        .rv   (rv_w)
    );

    // final add per mode and clip to the coordinate range
    logic signed [FW-1:0] fx, fy;
    logic signed [FW-1:0] bxf, byf;
    logic signed [CW-1:0] sx, sy;
    logic                 clip_x, clip_y;
    logic signed [CW-1:0] rx_reg, ry_reg;
    logic                 sat_reg;

    assign bxf = FW'(bx_dly_reg[DLY_B-1]);
    assign byf = FW'(by_dly_reg[DLY_B-1]);

    always_comb begin
        case (req_dly_reg[DLY_B-1])
            REQ_FWD: begin
                fx = bxf + FW'(ru_w);
                fy = byf + FW'(rv_w);
            end
            REQ_REV: begin
                fx = FW'(ru_w);
                fy = left_dly_reg[DLY_B-1] ? FW'(rv_w) : -FW'(rv_w);
            end
            REQ_BASE: begin
                fx = bxf - FW'(ru_w);
                fy = byf - FW'(rv_w);
            end
            default: begin
                fx = '0;
                fy = '0;
            end
        endcase

        clip_x = (fx > MAXV) || (fx < MINV);
        clip_y = (fy > MAXV) || (fy < MINV);
        sx = (fx > MAXV) ? CW'(MAXV) : ((fx < MINV) ? CW'(MINV) : CW'(fx));
        sy = (fy > MAXV) ? CW'(MAXV) : ((fy < MINV) ? CW'(MINV) : CW'(fy));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rx_reg  <= sx;
            ry_reg  <= sy;
            sat_reg <= clip_x || clip_y;
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = OUT_W'({ry_reg, rx_reg});
    assign m_tuser  = sat_reg;

endmodule

[rtl/lft_checker.sv]
// port-level checks for local_frame_transform, bound to the top level
// depends on lft_pkg
module lft_checker
    import lft_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int OUT_W       = ((2 * COORD_WIDTH_DEF + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);

    localparam logic [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [COORD_WIDTH-1:0] rx, ry;
    assign rx = m_tdata[COORD_WIDTH-1:0];
    assign ry = m_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

    // pending result stays valid until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // input side follows the output slot
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready out of step with output slot");

    // a clipped result sits on a range limit
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (rx == MAXV || rx == MINV || ry == MAXV || ry == MINV))
        else $error("saturated flag without a clipped coordinate");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind local_frame_transform lft_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .OUT_W       (OUT_W)
) u_lft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
